// ===== design/spaced_seed_mismatch_cover_check_top_defines.svh =====
// ----------------------------------------------------------------------------
// Spaced seed mismatch cover check - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SPACED_SEED_MISMATCH_COVER_CHECK_TOP_DEFINES_SVH
`define SPACED_SEED_MISMATCH_COVER_CHECK_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication violated");

// next-cycle implication, checked outside reset
`define SSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// ===== design/sscc_pkg.sv =====
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared widths, register indexes and beat types of the cover check.
// ----------------------------------------------------------------------------
package sscc_pkg;

  localparam int unsigned MAX_OLIGO        = 32;
  localparam int unsigned MAX_MISMATCH_DEF = 4;

  localparam int unsigned MASK_W  = 32;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned MISS_W  = 3;
  localparam int unsigned POS_W   = $clog2(MAX_OLIGO);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OLIGO_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MISMATCH = 1'd1;

  localparam logic [LEN_W-1:0]  OLIGO_LENGTH_RST = 6'd32;
  localparam logic [MISS_W-1:0] MAX_MISMATCH_RST = 3'd2;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [LEN_W-1:0]  slen;
    logic [LEN_W-1:0]  olen;
  } job_t;

  typedef struct packed {
    logic              done;
    logic              good;
    logic [MASK_W-1:0] mask;
  } res_t;

endpackage

// ===== design/sscc_cover.sv =====
// ----------------------------------------------------------------------------
// sscc_cover
// Shared compare unit: tests one mismatch mask against every seed offset.
// ----------------------------------------------------------------------------
module sscc_cover (
  input  logic [sscc_pkg::SEED_W-1:0] seed_i,
  input  logic [sscc_pkg::LEN_W-1:0]  slen_i,
  input  logic [sscc_pkg::LEN_W-1:0]  olen_i,
  input  logic [sscc_pkg::MASK_W-1:0] mask_i,
  output logic                        covered_o
);
  import sscc_pkg::*;

  logic [MAX_OLIGO-1:0] hit;

  // an offset hits when the seed fits there and no care bit meets a mismatch
  always_comb begin
    for (int off = 0; off < MAX_OLIGO; off++) begin
      hit[off] = ((LEN_W + 1)'(off) + {1'b0, slen_i} <= {1'b0, olen_i}) &&
                 (((seed_i << off) & mask_i) == '0);
    end
  end

  assign covered_o = (slen_i == '0) || (|hit);

endmodule

// ===== design/sscc_search.sv =====
// ----------------------------------------------------------------------------
// sscc_search
// Sequencer that walks mismatch sets depth first, one set per check cycle.
// ----------------------------------------------------------------------------
module sscc_search #(
  parameter  int unsigned MaxMismatch = sscc_pkg::MAX_MISMATCH_DEF,
  localparam int unsigned LvlW        = $clog2(MaxMismatch + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  sscc_pkg::job_t    job_i,
  input  logic [LvlW-1:0]   miss_i,
  output logic              busy_o,
  output sscc_pkg::res_t    res_o
);
  import sscc_pkg::*;

  localparam int unsigned IdxW = (MaxMismatch > 1) ? $clog2(MaxMismatch) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [SEED_W-1:0] seed_q;
  logic [LEN_W-1:0]  slen_q, olen_q;
  logic [LvlW-1:0]   miss_q;
  logic [POS_W-1:0]  stk_q [MaxMismatch];
  res_t              res_q, res_d;

  logic              stk_we;
  logic [IdxW-1:0]   stk_widx;
  logic [POS_W-1:0]  stk_wdata;

  logic [LvlW-1:0]   lvl_m1;
  logic [POS_W-1:0]  last;
  logic [POS_W:0]    nxt;
  logic              room;
  logic [MASK_W-1:0] last_bit, nxt_bit;
  logic              covered;

  sscc_cover u_cover (
    .seed_i    (seed_q),
    .slen_i    (slen_q),
    .olen_i    (olen_q),
    .mask_i    (mask_q),
    .covered_o (covered)
  );

  assign lvl_m1   = lvl_q - LvlW'(1);
  assign last     = stk_q[lvl_m1[IdxW-1:0]];
  assign nxt      = {1'b0, last} + (POS_W + 1)'(1);
  assign room     = LEN_W'(nxt) < olen_q;
  assign last_bit = MASK_W'(1) << last;
  assign nxt_bit  = MASK_W'(1) << nxt[POS_W-1:0];

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    mask_d    = mask_q;
    res_d     = '0;
    stk_we    = 1'b0;
    stk_widx  = lvl_m1[IdxW-1:0];
    stk_wdata = nxt[POS_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          if (job_i.olen == '0 || miss_i == '0) begin
            res_d.done = 1'b1;
            res_d.good = 1'b1;
          end else begin
            // open the search with the set {0}
            stk_we    = 1'b1;
            stk_widx  = '0;
            stk_wdata = '0;
            lvl_d     = LvlW'(1);
            mask_d    = MASK_W'(1);
            state_d   = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (!covered) begin
          res_d.done = 1'b1;
          res_d.mask = mask_q;
          state_d    = S_IDLE;
        end else if (lvl_q < miss_q && room) begin
          stk_we   = 1'b1;
          stk_widx = lvl_q[IdxW-1:0];
          lvl_d    = lvl_q + LvlW'(1);
          mask_d   = mask_q | nxt_bit;
        end else if (room) begin
          stk_we = 1'b1;
          mask_d = (mask_q & ~last_bit) | nxt_bit;
        end else begin
          lvl_d   = lvl_m1;
          mask_d  = mask_q & ~last_bit;
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (lvl_q == '0) begin
          res_d.done = 1'b1;
          res_d.good = 1'b1;
          state_d    = S_IDLE;
        end else if (room) begin
          stk_we  = 1'b1;
          mask_d  = (mask_q & ~last_bit) | nxt_bit;
          state_d = S_STEP;
        end else begin
          // drop the exhausted level and keep unwinding
          lvl_d  = lvl_m1;
          mask_d = mask_q & ~last_bit;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      mask_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      mask_q  <= mask_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && go_i) begin
      seed_q <= job_i.seed;
      slen_q <= job_i.slen;
      olen_q <= job_i.olen;
      miss_q <= miss_i;
    end
    if (stk_we) begin
      stk_q[stk_widx] <= stk_wdata;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

endmodule

// ===== design/spaced_seed_mismatch_cover_check_top.sv =====
// ----------------------------------------------------------------------------
// spaced_seed_mismatch_cover_check_top
// Checks that a spaced seed survives every small set of oligo mismatches.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to hand over a seed. A seed longer than
// the oligo answers with length_error_o in the cycle after the start. Otherwise
// a search runs: each mismatch set visited gets a check step (all offsets are
// compared at once by the shared cover unit), each backtrack gets a step of
// its own, and the result shows in the cycle after the search stops. done_o
// marks each result for one cycle only and cannot be held off; capture
// good_o, length_error_o and failing_mask_o while it is high. Write
// configuration only while idle.
// ----------------------------------------------------------------------------
module spaced_seed_mismatch_cover_check_top #(
  parameter int unsigned MaxMismatch = sscc_pkg::MAX_MISMATCH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sscc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sscc_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [sscc_pkg::SEED_W-1:0]    seed_pattern_i,
  input  logic [sscc_pkg::LEN_W-1:0]     seed_length_i,
  output logic                           done_o,
  output logic                           good_o,
  output logic                           length_error_o,
  output logic [sscc_pkg::MASK_W-1:0]    failing_mask_o
);
  import sscc_pkg::*;

  localparam int unsigned LvlW = $clog2(MaxMismatch + 1);

  logic [LEN_W-1:0]  oligo_length_q;
  logic [MISS_W-1:0] max_mismatch_q;
  logic              err_done_q;

  logic [LEN_W-1:0]  olen_eff;
  logic [LvlW-1:0]   miss_eff;
  logic              accept;
  logic              len_err;
  logic [SEED_W:0]   care_mask;
  job_t              job;
  res_t              res;
  logic              srch_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oligo_length_q <= OLIGO_LENGTH_RST;
      max_mismatch_q <= MAX_MISMATCH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OLIGO_LENGTH: oligo_length_q <= cfg_wdata_i;
        REG_MAX_MISMATCH: max_mismatch_q <= cfg_wdata_i[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  assign olen_eff = (oligo_length_q > LEN_W'(MAX_OLIGO)) ? LEN_W'(MAX_OLIGO) : oligo_length_q;
  assign miss_eff = ({1'b0, max_mismatch_q} > (MISS_W + 1)'(MaxMismatch)) ?
                    LvlW'(MaxMismatch) : LvlW'(max_mismatch_q);

  assign accept    = start_i && !busy_o;
  assign len_err   = seed_length_i > olen_eff;
  // keep only seed positions below the seed length
  assign care_mask = ((SEED_W + 1)'(1) << seed_length_i) - (SEED_W + 1)'(1);

  assign job.seed = seed_pattern_i & care_mask[SEED_W-1:0];
  assign job.slen = seed_length_i;
  assign job.olen = olen_eff;

  sscc_search #(
    .MaxMismatch (MaxMismatch)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept && !len_err),
    .job_i  (job),
    .miss_i (miss_eff),
    .busy_o (srch_busy),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_done_q <= 1'b0;
    end else begin
      err_done_q <= accept && len_err;
    end
  end

  assign busy_o         = srch_busy;
  assign done_o         = err_done_q || res.done;
  assign good_o         = res.done && res.good;
  assign length_error_o = err_done_q;
  assign failing_mask_o = res.done ? res.mask : '0;

endmodule

// ===== design/sscc_checker.sv =====
// ----------------------------------------------------------------------------
// sscc_checker
// Port-level checks of the cover check results, bound to the top level.
// ----------------------------------------------------------------------------
`include "spaced_seed_mismatch_cover_check_top_defines.svh"

module sscc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic                           good_o,
  input logic                           length_error_o,
  input logic [sscc_pkg::MASK_W-1:0]    failing_mask_o
);

  // a beat is good, a length error, or a failure, never two at once
  `SSCC_ASSERT_IMP(a_one_verdict, clk_i, rst_ni, done_o, !(good_o && length_error_o))

  `SSCC_ASSERT_IMP(a_mask_zero, clk_i, rst_ni, good_o || length_error_o, failing_mask_o == '0)

  // the empty set is always covered, so a failure names at least one position
  `SSCC_ASSERT_IMP(a_fail_mask_set, clk_i, rst_ni,
                   done_o && !good_o && !length_error_o, failing_mask_o != '0)

  `SSCC_ASSERT_IMP(a_busy_from_start, clk_i, rst_ni, $rose(busy_o), $past(start_i))

  // a length error beat comes straight from a start, never from a search
  `SSCC_ASSERT_NXT(a_err_after_start, clk_i, rst_ni, busy_o, !length_error_o)

endmodule

bind spaced_seed_mismatch_cover_check_top sscc_checker u_sscc_checker (.*);
